>>> src/pidpwm_pkg.sv
`timescale 1ns / 1ps
// pidpwm_pkg: shared widths, register indexes, reset values, sequencer states
// and width helper functions for the position pid / pwm axis block
// no dependencies
package pidpwm_pkg;

   // transaction field widths
   localparam int RAW_W  = 16;
   localparam int TGT_W  = 16;
   localparam int DUTY_W = 8;

   // default structural parameters
   localparam int AVG_TAPS_DEFAULT    = 4;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 36;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_RATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_RATE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_SLOPE  = 3'd4;

   localparam int KP_W  = 32;
   localparam int KI_W  = 32;
   localparam int KD_W  = 36;
   localparam int PWM_W = 8;

   localparam logic [KP_W-1:0]  KP_RESET     = 32'd5586690;
   localparam logic [KI_W-1:0]  KI_RESET     = 32'd2280797;
   localparam logic [KD_W-1:0]  KD_RESET     = 36'd26969374720;
   localparam logic [PWM_W-1:0] OFFSET_RESET = 8'd135;
   localparam logic [PWM_W-1:0] SLOPE_RESET  = 8'd24;

   // error path
   localparam int ERR_W  = 20;
   localparam int DERR_W = ERR_W + 1;
   localparam int ESUM_W = 48;
   localparam int SUMX_W = ESUM_W + 1;
   localparam logic signed [ERR_W-1:0]  ERR_HI  = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic signed [ERR_W-1:0]  ERR_LO  = {1'b1, {(ERR_W-1){1'b0}}};
   localparam logic signed [ESUM_W-1:0] ESUM_HI = {1'b0, {(ESUM_W-1){1'b1}}};
   localparam logic signed [ESUM_W-1:0] ESUM_LO = {1'b1, {(ESUM_W-1){1'b0}}};

   // shared multiplier
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // drive accumulation, units of 2^-26
   localparam int ISPLIT_W = 24;
   localparam int LO_W     = KI_W + ISPLIT_W;
   localparam int IQX_W    = 64;
   localparam int IQ_W     = 61;
   localparam int U_W      = 63;
   localparam int UMAG_W   = U_W - 1;
   localparam logic [IQX_W-1:0]  ITERM_CLAMP = 64'h1000_0000_0000_0000;
   localparam int DRIVE_SHIFT = 26;
   localparam logic [UMAG_W-1:0] DRIVE_LIMIT = UMAG_W'(5) << DRIVE_SHIFT;
   localparam int DMAG_W  = 29;
   localparam int DTERM_W = 11;
   localparam int DSUM_W  = 12;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_MUL,
      ST_AVG_FIX,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_ILO,
      ST_MUL_IHI,
      ST_ITERM,
      ST_ACCUM,
      ST_MAG,
      ST_MUL_DUTY,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] op_a;
      logic [MUL_B_W-1:0] op_b;
   } mul_req_type;

   // width of one stored sample
   function automatic int smp_width(input int count_width);
      return (count_width > RAW_W) ? RAW_W + 1 : count_width;
   endfunction

   // width of the running sum over the store
   function automatic int acc_width(input int taps, input int count_width);
      return smp_width(count_width) + $clog2(taps);
   endfunction

endpackage

>>> src/pidpwm_if.sv
`timescale 1ns / 1ps
// pidpwm_req_if / pidpwm_rsp_if: valid/ready channels for the axis block
// depends on pidpwm_pkg
interface pidpwm_req_if import pidpwm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [RAW_W-1:0]        raw_count;
   logic signed [TGT_W-1:0] target_position;

   modport source (output valid, output raw_count, output target_position, input ready);
   modport sink   (input valid, input raw_count, input target_position, output ready);
endinterface

interface pidpwm_rsp_if import pidpwm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] pwm_duty;
   logic              forward;
   logic              saturated;

   modport source (output valid, output pwm_duty, output forward, output saturated,
                   input ready);
   modport sink   (input valid, input pwm_duty, input forward, input saturated,
                   output ready);
endinterface

>>> src/pidpwm_mul.sv
`timescale 1ns / 1ps
// pidpwm_mul: shared unsigned multiplier with registered product
// depends on pidpwm_pkg
module pidpwm_mul import pidpwm_pkg::*; (
   input  logic               clock,
   input  mul_req_type        req,
   output logic [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= MUL_P_W'(req.op_a) * MUL_P_W'(req.op_b);
      end
   end

   assign prod = prod_ff;

endmodule

>>> src/pidpwm_avg.sv
`timescale 1ns / 1ps
// pidpwm_avg: decoder word unswap, sample store and running sum
// depends on pidpwm_pkg
module pidpwm_avg import pidpwm_pkg::*; #(
   parameter int AVG_TAPS    = AVG_TAPS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           push,
   input  logic [RAW_W-1:0]                               raw_count,
   output logic signed [acc_width(AVG_TAPS, COUNT_WIDTH)-1:0] run_sum
);

   localparam int SMP_W = smp_width(COUNT_WIDTH);
   localparam int TAP_W = $clog2(AVG_TAPS);
   localparam int ACC_W = acc_width(AVG_TAPS, COUNT_WIDTH);

   logic [RAW_W-1:0]        swapped;
   logic [RAW_W:0]          swapped_ext;
   logic signed [SMP_W-1:0] sample;
   logic signed [SMP_W-1:0] tap_ff [AVG_TAPS];
   logic [TAP_W-1:0]        ptr_ff;
   logic signed [ACC_W-1:0] run_sum_ff;

   // swap each adjacent bit pair back
   always_comb begin
      for (int k = 0; k < RAW_W / 2; k++) begin
         swapped[2*k]   = raw_count[2*k+1];
         swapped[2*k+1] = raw_count[2*k];
      end
   end

   // narrow counts sign extend, wide ones stay positive
   assign swapped_ext = {1'b0, swapped};
   assign sample      = signed'(swapped_ext[SMP_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AVG_TAPS; k++) begin
            tap_ff[k] <= '0;
         end
         ptr_ff     <= '0;
         run_sum_ff <= '0;
      end else if (push) begin
         tap_ff[ptr_ff] <= sample;
         ptr_ff         <= (ptr_ff == TAP_W'(AVG_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
         run_sum_ff     <= run_sum_ff - ACC_W'(tap_ff[ptr_ff]) + ACC_W'(sample);
      end
   end

   assign run_sum = run_sum_ff;

endmodule

>>> src/position_pid_pwm_axis_top.sv
`timescale 1ns / 1ps
// position_pid_pwm_axis_top: one axis of a pid position controller with pwm duty output
// depends on pidpwm_pkg, pidpwm_if, pidpwm_avg, pidpwm_mul
//
// usage
//   req_ch carries one control tick per transaction: the raw decoder word and the
//   target position. rsp_ch returns one transaction per tick: duty, direction and a
//   saturation flag. gains and pwm mapping are written via csr_we/csr_index/csr_wdata,
//   by the user only while the block is idle (unenforced); unknown indexes are ignored.
// timing
//   one 36x24 multiplier is shared by every product (average reciprocal, p, d,
//   two halves of the i term, duty slope) under a 13-state sequencer. req_ch.ready
//   is high again in the same cycle the result is presented.
//   req_ch.ready is high only while the sequencer is idle.
// stalls
//   results sit in an output register; the next tick is accepted while it waits.
//   a finished tick holds in its last state until the output register is free.
// reset
//   synchronous, active high: registers go to their reset values, the sample
//   store, error sum and last error clear, and no result is pending.
module position_pid_pwm_axis_top import pidpwm_pkg::*; #(
   parameter int AVG_TAPS    = AVG_TAPS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   pidpwm_req_if.sink            req_ch,
   pidpwm_rsp_if.source          rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // average datapath widths
   localparam int ACC_W = acc_width(AVG_TAPS, COUNT_WIDTH);
   localparam int NUM_W = ACC_W + 2;
   localparam int MAG_W = NUM_W;
   localparam int RECIP = (2 ** MAG_W) / AVG_TAPS;
   localparam int DIF_W = ((NUM_W > ERR_W - 1) ? NUM_W : ERR_W - 1) + 1;
   localparam logic signed [DIF_W-1:0] DIF_HI = DIF_W'(ERR_HI);
   localparam logic signed [DIF_W-1:0] DIF_LO = DIF_W'(ERR_LO);

   // configuration registers
   logic [KP_W-1:0]  kp_ff;
   logic [KI_W-1:0]  ki_ff;
   logic [KD_W-1:0]  kd_ff;
   logic [PWM_W-1:0] offset_ff;
   logic [PWM_W-1:0] slope_ff;

   // sequencer
   seq_state_type state_ff, state_in;
   logic          req_hs;
   logic          out_load;

   // datapath registers
   logic signed [TGT_W-1:0]  target_ff;
   logic [MAG_W-1:0]         n_mag_ff;
   logic                     n_neg_ff;
   logic signed [NUM_W-1:0]  avg_q_ff;
   logic signed [ERR_W-1:0]  e_ff;
   logic signed [DERR_W-1:0] d_ff;
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [ESUM_W-1:0] err_sum_ff;
   logic [ESUM_W-1:0]        smag_ff;
   logic                     s_neg_ff;
   logic [LO_W-1:0]          lo_ff;
   logic [IQ_W-1:0]          iq_ff;
   logic                     frac_ff;
   logic signed [U_W-1:0]    acc_ff;
   logic [UMAG_W-1:0]        mag_ff;
   logic                     sat_ff;
   logic                     fwd_ff;

   // result register
   logic              rsp_valid_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic              rsp_fwd_ff;
   logic              rsp_sat_ff;

   // combinational values
   logic signed [ACC_W-1:0]  run_sum;
   logic signed [NUM_W-1:0]  avg_num;
   logic                     avg_neg;
   logic [MAG_W-1:0]         avg_mag;
   logic [MAG_W-1:0]         q0, r0, q1;
   logic                     fix, rem_nz;
   logic signed [NUM_W-1:0]  q_s;
   logic signed [NUM_W-1:0]  avg_q_in;
   logic signed [DIF_W-1:0]  diff;
   logic signed [ERR_W-1:0]  e_in;
   logic signed [DERR_W-1:0] d_in;
   logic [ERR_W-1:0]         e_mag;
   logic [DERR_W-1:0]        d_mag;
   logic signed [SUMX_W-1:0] sumx;
   logic signed [ESUM_W-1:0] err_sum_in;
   logic [MUL_P_W-1:0]       prod;
   logic signed [U_W-1:0]    prod_s;
   logic signed [U_W-1:0]    prod_term;
   logic [IQX_W-1:0]         iq_raw;
   logic                     iq_clamp;
   logic signed [U_W-1:0]    iq_s;
   logic signed [U_W-1:0]    iterm;
   logic [UMAG_W-1:0]        umag;
   logic [DSUM_W-1:0]        duty_sum;
   logic [DUTY_W-1:0]        duty_in;
   mul_req_type              mul_req;

   assign req_hs   = req_ch.valid && req_ch.ready;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pwm_duty  = rsp_duty_ff;
   assign rsp_ch.forward   = rsp_fwd_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // sample store and running sum, updated on the accepting edge
   pidpwm_avg #(
      .AVG_TAPS    (AVG_TAPS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_avg (
      .clock     (clock),
      .reset     (reset),
      .push      (req_hs),
      .raw_count (req_ch.raw_count),
      .run_sum   (run_sum)
   );

   pidpwm_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= KP_RESET;
         ki_ff     <= KI_RESET;
         kd_ff     <= KD_RESET;
         offset_ff <= OFFSET_RESET;
         slope_ff  <= SLOPE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KP_GAIN:    kp_ff     <= csr_wdata[KP_W-1:0];
            CSR_KI_RATE:    ki_ff     <= csr_wdata[KI_W-1:0];
            CSR_KD_RATE:    kd_ff     <= csr_wdata[KD_W-1:0];
            CSR_PWM_OFFSET: offset_ff <= csr_wdata[PWM_W-1:0];
            CSR_PWM_SLOPE:  slope_ff  <= csr_wdata[PWM_W-1:0];
            default: ;
         endcase
      end
   end

   // floor(4*sum/taps): reciprocal multiply, then one correction step
   assign avg_num = {run_sum, 2'b00};
   assign avg_neg = avg_num[NUM_W-1];
   assign avg_mag = avg_neg ? MAG_W'(-avg_num) : MAG_W'(avg_num);

   assign q0     = prod[MAG_W +: MAG_W];
   assign r0     = n_mag_ff - MAG_W'(q0 * MAG_W'(AVG_TAPS));
   assign fix    = (r0 >= MAG_W'(AVG_TAPS));
   assign q1     = q0 + MAG_W'(fix);
   assign rem_nz = fix ? (r0 != MAG_W'(AVG_TAPS)) : (r0 != '0);
   assign q_s    = signed'(q1);
   assign avg_q_in = n_neg_ff ? -(q_s + signed'(NUM_W'(rem_nz))) : q_s;

   // error in quarter counts, saturated to its range
   assign diff = (DIF_W'(target_ff) <<< 2) - DIF_W'(avg_q_ff);
   assign e_in = (diff > DIF_HI) ? ERR_HI :
                 (diff < DIF_LO) ? ERR_LO : diff[ERR_W-1:0];
   assign d_in = DERR_W'(e_in) - DERR_W'(last_err_ff);

   assign e_mag = e_ff[ERR_W-1]  ? ERR_W'(-e_ff)  : ERR_W'(e_ff);
   assign d_mag = d_ff[DERR_W-1] ? DERR_W'(-d_ff) : DERR_W'(d_ff);

   // saturating error sum
   assign sumx       = SUMX_W'(err_sum_ff) + SUMX_W'(e_ff);
   assign err_sum_in = (sumx > SUMX_W'(ESUM_HI)) ? ESUM_HI :
                       (sumx < SUMX_W'(ESUM_LO)) ? ESUM_LO : sumx[ESUM_W-1:0];

   // signed view of the last product for the p and d terms
   assign prod_s    = signed'(U_W'(prod));
   assign prod_term = (state_ff == ST_MUL_D) ? (e_ff[ERR_W-1] ? -prod_s : prod_s)
                                             : (d_ff[DERR_W-1] ? -prod_s : prod_s);

   // i term: high half shifted up by 8, low half down by 16, clamped
   assign iq_raw   = (IQX_W'(prod) << 8) + IQX_W'(lo_ff >> 16);
   assign iq_clamp = (iq_raw > ITERM_CLAMP);
   assign iq_s     = signed'(U_W'(iq_ff));
   assign iterm    = s_neg_ff ? -(iq_s + signed'(U_W'(frac_ff))) : iq_s;

   assign umag = acc_ff[U_W-1] ? UMAG_W'(-acc_ff) : UMAG_W'(acc_ff);

   // duty: offset plus slope term, capped at full scale
   assign duty_sum = DSUM_W'(offset_ff) + DSUM_W'(prod[DRIVE_SHIFT +: DTERM_W]);
   assign duty_in  = sat_ff ? DUTY_MAX :
                     (duty_sum > DSUM_W'(DUTY_MAX)) ? DUTY_MAX : duty_sum[DUTY_W-1:0];

   // multiplier operand select
   always_comb begin
      mul_req.en   = 1'b1;
      mul_req.op_a = '0;
      mul_req.op_b = '0;
      case (state_ff)
         ST_AVG_MUL: begin
            mul_req.op_a = MUL_A_W'(avg_mag);
            mul_req.op_b = MUL_B_W'(RECIP);
         end
         ST_MUL_P: begin
            mul_req.op_a = MUL_A_W'(kp_ff);
            mul_req.op_b = MUL_B_W'(e_mag);
         end
         ST_MUL_D: begin
            mul_req.op_a = kd_ff;
            mul_req.op_b = MUL_B_W'(d_mag);
         end
         ST_MUL_ILO: begin
            mul_req.op_a = MUL_A_W'(ki_ff);
            mul_req.op_b = smag_ff[ISPLIT_W-1:0];
         end
         ST_MUL_IHI: begin
            mul_req.op_a = MUL_A_W'(ki_ff);
            mul_req.op_b = smag_ff[ESUM_W-1:ISPLIT_W];
         end
         ST_MUL_DUTY: begin
            mul_req.op_a = MUL_A_W'(mag_ff[DMAG_W-1:0]);
            mul_req.op_b = MUL_B_W'(slope_ff);
         end
         default: begin
            mul_req.en = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_hs) state_in = ST_AVG_MUL;
         ST_AVG_MUL:  state_in = ST_AVG_FIX;
         ST_AVG_FIX:  state_in = ST_ERROR;
         ST_ERROR:    state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_MUL_D;
         ST_MUL_D:    state_in = ST_MUL_ILO;
         ST_MUL_ILO:  state_in = ST_MUL_IHI;
         ST_MUL_IHI:  state_in = ST_ITERM;
         ST_ITERM:    state_in = ST_ACCUM;
         ST_ACCUM:    state_in = ST_MAG;
         ST_MAG:      state_in = ST_MUL_DUTY;
         ST_MUL_DUTY: state_in = ST_DONE;
         ST_DONE:     if (out_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // error history, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         err_sum_ff  <= '0;
      end else begin
         if (state_ff == ST_ERROR) begin
            last_err_ff <= e_in;
         end
         if (state_ff == ST_MUL_P) begin
            err_sum_ff <= err_sum_in;
         end
      end
   end

   // per-tick working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               target_ff <= req_ch.target_position;
            end
         end
         ST_AVG_MUL: begin
            n_mag_ff <= avg_mag;
            n_neg_ff <= avg_neg;
         end
         ST_AVG_FIX: begin
            avg_q_ff <= avg_q_in;
         end
         ST_ERROR: begin
            e_ff <= e_in;
            d_ff <= d_in;
         end
         ST_MUL_D: begin
            acc_ff   <= prod_term;
            s_neg_ff <= err_sum_ff[ESUM_W-1];
            smag_ff  <= err_sum_ff[ESUM_W-1] ? ESUM_W'(-err_sum_ff) : ESUM_W'(err_sum_ff);
         end
         ST_MUL_ILO: begin
            acc_ff <= acc_ff + prod_term;
         end
         ST_MUL_IHI: begin
            lo_ff <= prod[LO_W-1:0];
         end
         ST_ITERM: begin
            iq_ff   <= iq_clamp ? ITERM_CLAMP[IQ_W-1:0] : iq_raw[IQ_W-1:0];
            frac_ff <= !iq_clamp && (lo_ff[15:0] != '0);
         end
         ST_ACCUM: begin
            acc_ff <= acc_ff + iterm;
         end
         ST_MAG: begin
            mag_ff <= umag;
            sat_ff <= (umag >= DRIVE_LIMIT);
            fwd_ff <= !acc_ff[U_W-1];
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_duty_ff <= duty_in;
         rsp_fwd_ff  <= fwd_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

endmodule

>>> src/pidpwm_checker.sv
`timescale 1ns / 1ps
// pidpwm_checker: port-level checks for position_pid_pwm_axis_top, with bind
// depends on pidpwm_pkg and position_pid_pwm_axis_top
module pidpwm_checker import pidpwm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DUTY_W-1:0] rsp_pwm_duty,
   input logic              rsp_forward,
   input logic              rsp_saturated
);

   // one tick at a time: busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a tick is in progress");

   // no result can appear in the first cycles of a tick
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared too soon after a transaction");

   // saturated drive always gives full duty
   a_sat_full_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_pwm_duty == DUTY_MAX)
      else $error("saturated result without full duty");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pwm_duty)
         && $stable(rsp_forward) && $stable(rsp_saturated))
      else $error("stalled result changed");

endmodule

bind position_pid_pwm_axis_top pidpwm_checker u_pidpwm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_pwm_duty  (rsp_ch.pwm_duty),
   .rsp_forward   (rsp_ch.forward),
   .rsp_saturated (rsp_ch.saturated)
);
